FILE: rtl/core/ssaf_pkg.sv
// Shared types and constants for the state-space audio filter.
// Holds the fixed-point formats, the sequencer states and the control words
// passed between the sequencer, the multiply-accumulate unit and the top level.
package ssaf_pkg;

  localparam int NODES_DEF    = 7;
  localparam int COEF_W_DEF   = 32;
  localparam int SAMPLE_W_DEF = 24;

  localparam int COEF_FRAC = 24;
  localparam int ACC_FRAC  = 56;

  // Wide enough for a node index at the largest supported node count of 16.
  localparam int ROW_FIELD_W = 4;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RHS,
    ST_DRAIN_R,
    ST_VOLT,
    ST_DRAIN_V
  } state_t;

  typedef enum logic [1:0] {
    OPND_U,
    OPND_UPREV,
    OPND_V,
    OPND_R
  } opnd_sel_t;

  typedef struct packed {
    logic                   vld;
    logic                   first;
    logic                   last;
    logic                   neg;
    logic                   usel;
    logic                   dest_v;
    logic [ROW_FIELD_W-1:0] row;
  } mac_ctl_t;

  typedef struct packed {
    opnd_sel_t              sel;
    logic [ROW_FIELD_W-1:0] col;
  } opnd_req_t;

endpackage

FILE: rtl/core/ssaf_in_if.sv
// Input channel of the state-space audio filter: valid, ready and one item word.
// Depends on nothing; widths are set where the interface is instantiated.
interface ssaf_in_if #(
  parameter int IDX_W    = 7,
  parameter int SAMPLE_W = 24,
  parameter int COEF_W   = 32
);
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic        [IDX_W-1:0]    coef_index;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, output op, output sample_in, output coef_index,
                  output coef_value, input ready);
  modport sink (input valid, input op, input sample_in, input coef_index,
                input coef_value, output ready);
endinterface

FILE: rtl/core/ssaf_out_if.sv
// Result channel of the state-space audio filter: valid, ready and one sample word.
// Depends on nothing; the sample width is set where the interface is instantiated.
interface ssaf_out_if #(
  parameter int SAMPLE_W = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

FILE: rtl/core/ssaf_seq.sv
// Sequencer for the state-space audio filter: walks the right-hand side and the
// matrix-product phases, issuing one multiply-accumulate term per cycle.
// Depends on ssaf_pkg for states and control words.
module ssaf_seq #(
  parameter int NODES = ssaf_pkg::NODES_DEF,
  parameter int IDX_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 mac_busy,
  input  logic                 out_free,
  output logic                 in_ready,
  output logic                 done,
  output logic [IDX_W-1:0]     rd_addr,
  output ssaf_pkg::opnd_req_t  opnd,
  output ssaf_pkg::mac_ctl_t   ctl
);

  localparam int ROW_W  = $clog2(NODES);
  localparam int TERM_W = $clog2(NODES + 2);
  localparam int OFS_B  = NODES * NODES;
  localparam int OFS_C  = 2 * NODES * NODES;
  localparam int OFS_D  = OFS_C + NODES;

  localparam logic [TERM_W-1:0] RHS_LAST  = TERM_W'(NODES + 1);
  localparam logic [TERM_W-1:0] VOLT_LAST = TERM_W'(NODES - 1);
  localparam logic [TERM_W-1:0] GAIN_CNT  = TERM_W'(2);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(NODES - 1);

  ssaf_pkg::state_t    state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [TERM_W-1:0]   term_r, term_nxt;
  logic [IDX_W-1:0]    mat_r, mat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssaf_pkg::ST_IDLE;
      row_r   <= '0;
      term_r  <= '0;
      mat_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      term_r  <= term_nxt;
      mat_r   <= mat_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    term_nxt  = term_r;
    mat_nxt   = mat_r;
    case (state_r)
      ssaf_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = ssaf_pkg::ST_RHS;
          row_nxt   = '0;
          term_nxt  = '0;
          mat_nxt   = IDX_W'(OFS_B);
        end
      end
      ssaf_pkg::ST_RHS: begin
        if (term_r >= GAIN_CNT) begin
          mat_nxt = mat_r + 1'b1;
        end
        if (term_r == RHS_LAST) begin
          term_nxt = '0;
          if (row_r == ROW_LAST) begin
            state_nxt = ssaf_pkg::ST_DRAIN_R;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ssaf_pkg::ST_DRAIN_R: begin
        if (!mac_busy) begin
          state_nxt = ssaf_pkg::ST_VOLT;
          row_nxt   = '0;
          term_nxt  = '0;
          mat_nxt   = '0;
        end
      end
      ssaf_pkg::ST_VOLT: begin
        mat_nxt = mat_r + 1'b1;
        if (term_r == VOLT_LAST) begin
          term_nxt = '0;
          if (row_r == ROW_LAST) begin
            state_nxt = ssaf_pkg::ST_DRAIN_V;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          term_nxt = term_r + 1'b1;
        end
      end
      ssaf_pkg::ST_DRAIN_V: begin
        if (!mac_busy && out_free) begin
          state_nxt = ssaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    done     = 1'b0;
    rd_addr  = mat_r;
    opnd     = '0;
    ctl      = '0;
    case (state_r)
      ssaf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ssaf_pkg::ST_RHS: begin
        ctl.vld   = 1'b1;
        ctl.first = (term_r == '0);
        ctl.last  = (term_r == RHS_LAST);
        ctl.neg   = (term_r >= GAIN_CNT);
        ctl.usel  = (term_r < GAIN_CNT);
        ctl.row   = ssaf_pkg::ROW_FIELD_W'(row_r);
        if (term_r == '0) begin
          rd_addr  = IDX_W'(OFS_C) + IDX_W'(row_r);
          opnd.sel = ssaf_pkg::OPND_U;
        end else if (term_r == TERM_W'(1)) begin
          rd_addr  = IDX_W'(OFS_D) + IDX_W'(row_r);
          opnd.sel = ssaf_pkg::OPND_UPREV;
        end else begin
          opnd.sel = ssaf_pkg::OPND_V;
          opnd.col = ssaf_pkg::ROW_FIELD_W'(term_r - GAIN_CNT);
        end
      end
      ssaf_pkg::ST_VOLT: begin
        ctl.vld    = 1'b1;
        ctl.first  = (term_r == '0);
        ctl.last   = (term_r == VOLT_LAST);
        ctl.dest_v = 1'b1;
        ctl.row    = ssaf_pkg::ROW_FIELD_W'(row_r);
        opnd.sel   = ssaf_pkg::OPND_R;
        opnd.col   = ssaf_pkg::ROW_FIELD_W'(term_r);
      end
      ssaf_pkg::ST_DRAIN_V: begin
        done = !mac_busy && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/ssaf_mac.sv
// Shared multiply-accumulate unit: registered product, exact wide accumulator,
// then rounding to 24 fraction bits and saturation on the last term of a row.
// Depends on ssaf_pkg for the fixed-point formats and the control word.
module ssaf_mac #(
  parameter int NODES    = ssaf_pkg::NODES_DEF,
  parameter int COEF_W   = ssaf_pkg::COEF_W_DEF,
  parameter int SAMPLE_W = ssaf_pkg::SAMPLE_W_DEF,
  parameter int OPND_W   = ssaf_pkg::COEF_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ssaf_pkg::mac_ctl_t        ctl_in,
  input  logic signed [COEF_W-1:0]  coef,
  input  logic signed [OPND_W-1:0]  opnd,
  output logic                      busy,
  output ssaf_pkg::mac_ctl_t        wb_ctl,
  output logic signed [COEF_W-1:0]  wb_value
);

  localparam int PROD_W = COEF_W + OPND_W;
  localparam int VSH    = ssaf_pkg::ACC_FRAC - 2 * ssaf_pkg::COEF_FRAC;
  localparam int USH    = ssaf_pkg::ACC_FRAC - ssaf_pkg::COEF_FRAC - (SAMPLE_W - 1);
  localparam int MAX_SH = (VSH > USH) ? VSH : USH;
  localparam int ACC_W  = PROD_W + MAX_SH + $clog2(NODES + 2) + 1;
  localparam int RND_SH = ssaf_pkg::ACC_FRAC - ssaf_pkg::COEF_FRAC;
  localparam int Q_W    = ACC_W - RND_SH;

  ssaf_pkg::mac_ctl_t        ctl1_r, ctl2_r, ctl3_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   rnd;
  logic        [Q_W-1:0]     q;
  logic        [Q_W-COEF_W:0] q_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * opnd;
    if (ctl2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    if (ctl2_r.usel) begin
      term = ACC_W'(prod_r) <<< USH;
    end else begin
      term = ACC_W'(prod_r) <<< VSH;
    end
    acc_base = ctl2_r.first ? '0 : acc_r;
    acc_nxt  = ctl2_r.neg ? (acc_base - term) : (acc_base + term);
  end

  always_comb begin
    rnd  = acc_r + (ACC_W'(1) <<< (RND_SH - 1));
    q    = rnd[ACC_W-1:RND_SH];
    q_hi = q[Q_W-1:COEF_W-1];
    if ((q_hi == '0) || (q_hi == '1)) begin
      wb_value = q[COEF_W-1:0];
    end else if (q[Q_W-1]) begin
      wb_value = {1'b1, {(COEF_W - 1){1'b0}}};
    end else begin
      wb_value = {1'b0, {(COEF_W - 1){1'b1}}};
    end
  end

  always_comb begin
    wb_ctl     = ctl3_r;
    wb_ctl.vld = ctl3_r.vld & ctl3_r.last;
    busy       = ctl1_r.vld | ctl2_r.vld | ctl3_r.vld;
  end

endmodule

FILE: rtl/core/state_space_audio_filter.sv
// State-space audio filter: a discretised circuit of NODES nodes, one sample per item.
// Each input word is either a coefficient load (op high) or an audio sample (op low).
// A load writes one word of the coefficient store (inverse matrix, feedback matrix,
// input gain and previous-input gain, row-major) and is taken with no result; an
// index beyond the store is ignored. All coefficients are to be loaded before the
// first sample.
// A sample forms the right-hand side from the input, the previous input and the
// previous node voltages, multiplies it by the inverse matrix and returns node 0
// rounded and saturated to the sample format. Every product goes through one
// shared multiply-accumulate unit, one term per cycle while a phase runs and with a
// wait for the unit to drain between phases; in_ch.ready is low from acceptance
// until the result word is written.
// The result sits in an output register; a new load or sample is taken while it
// waits. If the receiver still holds back the previous result when the next one
// is ready, the block waits in its final step until the register is free.
// Reset clears the node voltages, the previous input and all handshake state; the
// coefficient store keeps whatever it held and must be loaded again.
// Depends on ssaf_pkg, ssaf_in_if, ssaf_out_if, ssaf_seq and ssaf_mac.
module state_space_audio_filter #(
  parameter int NODES        = ssaf_pkg::NODES_DEF,
  parameter int COEF_WIDTH   = ssaf_pkg::COEF_W_DEF,
  parameter int SAMPLE_WIDTH = ssaf_pkg::SAMPLE_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ssaf_in_if.sink   in_ch,
  ssaf_out_if.source out_ch
);

  localparam int COEF_COUNT = 2 * NODES * NODES + 2 * NODES;
  localparam int IDX_W      = $clog2(COEF_COUNT);
  localparam int ROW_W      = $clog2(NODES);
  localparam int OPND_W     = (COEF_WIDTH > SAMPLE_WIDTH) ? COEF_WIDTH : SAMPLE_WIDTH;
  localparam int OUT_PRE    = ssaf_pkg::ACC_FRAC - 2 * ssaf_pkg::COEF_FRAC;
  localparam int OUT_SH     = ssaf_pkg::COEF_FRAC + OUT_PRE - (SAMPLE_WIDTH - 1);
  localparam int OUT_W      = COEF_WIDTH + OUT_PRE + SAMPLE_WIDTH;

  logic signed [COEF_WIDTH-1:0]   coef_mem [COEF_COUNT];
  logic signed [COEF_WIDTH-1:0]   coef_q_r;
  logic signed [OPND_W-1:0]       opnd_q_r, opnd_val;
  logic signed [COEF_WIDTH-1:0]   v_r   [NODES];
  logic signed [COEF_WIDTH-1:0]   rhs_r [NODES];
  logic signed [SAMPLE_WIDTH-1:0] u_r, prev_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r, out_sat;
  logic                           out_valid_r;

  logic                           in_acc, start, load_wr, out_free;
  logic                           seq_ready, seq_done, mac_busy;
  logic [IDX_W-1:0]               rd_addr;
  ssaf_pkg::opnd_req_t            opnd_req;
  ssaf_pkg::mac_ctl_t             issue_ctl, wb_ctl;
  logic signed [COEF_WIDTH-1:0]   wb_value;

  logic signed [OUT_W-1:0]        out_ext, out_rnd, out_q;
  logic [OUT_W-SAMPLE_WIDTH:0]    out_hi;

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign start    = in_acc && (in_ch.op == ssaf_pkg::OP_SAMPLE);
  assign load_wr  = in_acc && (in_ch.op == ssaf_pkg::OP_LOAD) &&
                    ({1'b0, in_ch.coef_index} < (IDX_W + 1)'(COEF_COUNT));
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = seq_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  ssaf_seq #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .mac_busy (mac_busy),
    .out_free (out_free),
    .in_ready (seq_ready),
    .done     (seq_done),
    .rd_addr  (rd_addr),
    .opnd     (opnd_req),
    .ctl      (issue_ctl)
  );

  ssaf_mac #(
    .NODES    (NODES),
    .COEF_W   (COEF_WIDTH),
    .SAMPLE_W (SAMPLE_WIDTH),
    .OPND_W   (OPND_W)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (issue_ctl),
    .coef     (coef_q_r),
    .opnd     (opnd_q_r),
    .busy     (mac_busy),
    .wb_ctl   (wb_ctl),
    .wb_value (wb_value)
  );

  always_ff @(posedge clk) begin
    if (load_wr) begin
      coef_mem[in_ch.coef_index] <= in_ch.coef_value;
    end
    coef_q_r <= coef_mem[rd_addr];
  end

  always_comb begin
    case (opnd_req.sel)
      ssaf_pkg::OPND_U:     opnd_val = OPND_W'(u_r);
      ssaf_pkg::OPND_UPREV: opnd_val = OPND_W'(prev_r);
      ssaf_pkg::OPND_V:     opnd_val = OPND_W'(v_r[opnd_req.col[ROW_W-1:0]]);
      ssaf_pkg::OPND_R:     opnd_val = OPND_W'(rhs_r[opnd_req.col[ROW_W-1:0]]);
      default:              opnd_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    opnd_q_r <= opnd_val;
    if (start) begin
      u_r <= in_ch.sample_in;
    end
    if (wb_ctl.vld && !wb_ctl.dest_v) begin
      rhs_r[wb_ctl.row[ROW_W-1:0]] <= wb_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '{default: '0};
      prev_r <= '0;
    end else begin
      if (wb_ctl.vld && wb_ctl.dest_v) begin
        v_r[wb_ctl.row[ROW_W-1:0]] <= wb_value;
      end
      if (seq_done) begin
        prev_r <= u_r;
      end
    end
  end

  always_comb begin
    out_ext = OUT_W'(v_r[0]) <<< OUT_PRE;
    out_rnd = out_ext + (OUT_W'(1) <<< (OUT_SH - 1));
    out_q   = out_rnd >>> OUT_SH;
    out_hi  = out_q[OUT_W-1:SAMPLE_WIDTH-1];
    if ((out_hi == '0) || (out_hi == '1)) begin
      out_sat = out_q[SAMPLE_WIDTH-1:0];
    end else if (out_q[OUT_W-1]) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_sample_r <= out_sat;
    end
  end

endmodule

FILE: rtl/core/ssaf_checker.sv
// Port-level checks for the state-space audio filter, attached by bind.
// Depends on ssaf_pkg for the operation codes and on the top level's ports.
module ssaf_checker #(
  parameter int SAMPLE_WIDTH = ssaf_pkg::SAMPLE_W_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_op,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample
);

  // A sample word occupies the shared unit, so the input must close behind it.
  a_sample_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == ssaf_pkg::OP_SAMPLE)) |=> !in_ready)
    else $error("input still ready after a sample word was taken");

  // A coefficient load leaves the input open.
  a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == ssaf_pkg::OP_LOAD)) |=> in_ready)
    else $error("input closed after a coefficient load");

  // A result word can only appear at the end of a sample computation.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared while the block was idle");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled result word changed or was dropped");

endmodule

bind state_space_audio_filter ssaf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ssaf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out)
);

FILE: tb/tb_state_space_audio_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the state-space audio filter: loads coefficient sets, feeds
// samples with random gaps and stalls, and checks every result word against a predictor.
// Depends on ssaf_pkg, ssaf_in_if, ssaf_out_if and state_space_audio_filter.
module tb_state_space_audio_filter;
  import ssaf_pkg::*;

  localparam int N          = NODES_DEF;
  localparam int CW         = COEF_W_DEF;
  localparam int SW         = SAMPLE_W_DEF;
  localparam int IDX_W      = 7;
  localparam int COEF_COUNT = 2 * N * N + 2 * N;
  localparam int OFS_B      = N * N;
  localparam int OFS_C      = 2 * N * N;
  localparam int OFS_D      = 2 * N * N + N;
  localparam int U_SHIFT    = ACC_FRAC - COEF_FRAC - (SW - 1);
  localparam int V_SHIFT    = ACC_FRAC - 2 * COEF_FRAC;
  localparam int LATENCY    = 2 * N * N + 2 * N + 8;
  localparam int RANDOM_ITEMS = 560;
  localparam int CYCLE_LIMIT  = 2000000;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};
  localparam longint COEF_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COEF_MIN = -COEF_MAX - 1;
  localparam longint COEF_ONE = 64'sd1 <<< COEF_FRAC;

  typedef logic signed [127:0] wide_t;
  typedef enum int {
    SET_TAME,
    SET_OPEN_LOOP,
    SET_WILD
  } coef_set_t;

  class node_voltage_predictor;
    longint coef[COEF_COUNT];
    longint volt[N];
    longint prev_u;
    logic signed [SW-1:0] expected_samples[$];
    int errors;

    function wide_t mul(longint a, longint b);
      wide_t x;
      wide_t y;
      x = wide_t'(a);
      y = wide_t'(b);
      return x * y;
    endfunction

    function wide_t round_sat(wide_t acc, int n, int w);
      wide_t t;
      wide_t maxv;
      wide_t minv;
      t = (acc + (128'sd1 <<< (n - 1))) >>> n;
      maxv = (128'sd1 <<< (w - 1)) - 1;
      minv = -maxv - 1;
      if (t < minv) return minv;
      if (t > maxv) return maxv;
      return t;
    endfunction

    function void take_word(op_t op, logic signed [SW-1:0] smp, int idx, longint value);
      longint rhs[N];
      longint u;
      wide_t acc;
      wide_t fb;
      wide_t out_w;
      if (op == OP_LOAD) begin
        if (idx < COEF_COUNT) coef[idx] = value;
        return;
      end
      u = longint'(smp);
      for (int i = 0; i < N; i++) begin
        acc = (mul(coef[OFS_C + i], u) + mul(coef[OFS_D + i], prev_u)) <<< U_SHIFT;
        fb = 0;
        for (int j = 0; j < N; j++) fb = fb + mul(coef[OFS_B + i * N + j], volt[j]);
        acc = acc - (fb <<< V_SHIFT);
        rhs[i] = longint'(round_sat(acc, ACC_FRAC - COEF_FRAC, CW));
      end
      for (int i = 0; i < N; i++) begin
        acc = 0;
        for (int j = 0; j < N; j++) acc = acc + mul(coef[i * N + j], rhs[j]);
        volt[i] = longint'(round_sat(acc <<< V_SHIFT, ACC_FRAC - COEF_FRAC, CW));
      end
      prev_u = u;
      out_w = wide_t'(volt[0]);
      out_w = round_sat(out_w <<< (ACC_FRAC - COEF_FRAC), ACC_FRAC - (SW - 1), SW);
      expected_samples.push_back(out_w[SW-1:0]);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (expected_samples.size() == 0) begin
        report($sformatf("result word %0d with none expected", got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want) report($sformatf("sample_out %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   hold_left;
  int   cycle_count;
  node_voltage_predictor predictor;

  ssaf_in_if #(.IDX_W(IDX_W), .SAMPLE_W(SW), .COEF_W(CW)) in_ch ();
  ssaf_out_if #(.SAMPLE_W(SW)) out_ch ();

  state_space_audio_filter #(
    .NODES(N),
    .COEF_WIDTH(CW),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("state_space_audio_filter test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) predictor.check_word(out_ch.sample_out);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_idle_pct != 0 && $urandom_range(3999) == 0) begin
      hold_left <= $urandom_range(300, 100);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic longint rand_scaled(int mag);
    longint raw;
    raw = {$urandom, $urandom};
    return raw >>> (63 - mag);
  endfunction

  function automatic longint pick_coef(int mag);
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      case ($urandom_range(4))
        0: return COEF_MAX;
        1: return COEF_MIN;
        2: return 0;
        3: return COEF_ONE;
        default: return -COEF_ONE;
      endcase
    end
    if (r < 12) return rand_scaled(CW - 1);
    return rand_scaled(mag);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      case ($urandom_range(4))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return '0;
        3: return SW'(1);
        default: return SW'(-1);
      endcase
    end
    if (r < 30) return SW'($signed($urandom_range(4095)) - 2048);
    return SW'($urandom);
  endfunction

  task automatic send_word(op_t op, logic signed [SW-1:0] smp, int idx, longint value);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.sample_in  <= smp;
    in_ch.coef_index <= idx[IDX_W-1:0];
    in_ch.coef_value <= value[CW-1:0];
    do @(posedge clk); while (!in_ch.ready);
    predictor.take_word(op, smp, idx, longint'($signed(value[CW-1:0])));
  endtask

  task automatic load_coef_set(coef_set_t kind);
    int mag;
    longint value;
    for (int idx = 0; idx < COEF_COUNT; idx++) begin
      if (kind == SET_WILD) mag = CW - 1;
      else if (idx < OFS_B) mag = 22;
      else if (idx < OFS_C) mag = 20;
      else mag = 23;
      value = pick_coef(mag);
      if (kind == SET_OPEN_LOOP && idx >= OFS_B && idx < OFS_C) value = 0;
      send_word(OP_LOAD, pick_sample(), idx, value);
    end
  endtask

  initial begin
    int done_items;
    int r;
    predictor = new();
    src_idle_pct  = 26;
    sink_idle_pct = 26;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_SAMPLE;
    in_ch.sample_in  <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    load_coef_set(SET_TAME);
    // Loads beyond the end of the store must leave it untouched.
    send_word(OP_LOAD, 0, COEF_COUNT, COEF_MAX);
    send_word(OP_LOAD, 0, (1 << IDX_W) - 1, COEF_MIN);
    send_word(OP_SAMPLE, 0, 0, 0);
    send_word(OP_SAMPLE, 1, 0, 0);
    send_word(OP_SAMPLE, -1, 0, 0);
    send_word(OP_SAMPLE, SAMPLE_MAX, 0, 0);
    send_word(OP_SAMPLE, SAMPLE_MIN, 0, 0);
    // Drive node 0 hard into saturation in both directions.
    send_word(OP_LOAD, 0, 0, COEF_MAX);
    send_word(OP_LOAD, 0, OFS_C, COEF_MAX);
    send_word(OP_SAMPLE, SAMPLE_MAX, 0, 0);
    send_word(OP_SAMPLE, SAMPLE_MIN, 0, 0);
    send_word(OP_SAMPLE, SAMPLE_MAX, 0, 0);
    send_word(OP_LOAD, 0, 0, COEF_MIN);
    send_word(OP_SAMPLE, SAMPLE_MAX, 0, 0);
    send_word(OP_LOAD, 0, 0, COEF_ONE);
    send_word(OP_LOAD, 0, OFS_C, COEF_ONE);
    send_word(OP_LOAD, 0, OFS_D, -COEF_ONE);
    send_word(OP_SAMPLE, 0, 0, 0);
    send_word(OP_SAMPLE, 0, 0, 0);
    send_word(OP_SAMPLE, SAMPLE_MAX, 0, 0);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items >= 250 && done_items < 400) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 26;
        sink_idle_pct = 26;
      end
      r = $urandom_range(999);
      if (r < 4 && done_items < 550) begin
        case ($urandom_range(2))
          0: load_coef_set(SET_TAME);
          1: load_coef_set(SET_OPEN_LOOP);
          default: load_coef_set(SET_WILD);
        endcase
        done_items += COEF_COUNT;
      end else if (r < 80) begin
        r = $urandom_range((1 << IDX_W) - 1);
        send_word(OP_LOAD, pick_sample(), r, pick_coef(22));
        if (r < COEF_COUNT) done_items++;
      end else begin
        send_word(OP_SAMPLE, pick_sample(), $urandom_range((1 << IDX_W) - 1), rand_scaled(31));
        done_items++;
      end
    end
    in_ch.valid <= 1'b0;

    while (predictor.expected_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (predictor.errors == 0) begin
      $display("state_space_audio_filter test passed");
    end else begin
      $display("state_space_audio_filter test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ssaf_pkg.sv
rtl/core/ssaf_in_if.sv
rtl/core/ssaf_out_if.sv
rtl/core/ssaf_seq.sv
rtl/core/ssaf_mac.sv
rtl/core/state_space_audio_filter.sv
rtl/core/ssaf_checker.sv
tb/tb_state_space_audio_filter.sv
